// File: sv/rxq_pkg.sv
package rxq_pkg;

    // Item kinds on the request channel
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_BYTE_TAKEN = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_TOO_LONG   = 3'd2,
        ST_FULL       = 3'd3,
        ST_BYTE_READ  = 3'd4,
        ST_EMPTY      = 3'd5
    } status_t;

    // Per-slot tag stored at commit
    typedef struct packed {
        logic [31:0] generation;
        logic [31:0] arrival;
    } slot_tag_t;

endpackage

// File: sv/rxq_if.sv
// Request channel: one push or pop word per handshake
interface rxq_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  in_byte;
    logic        last_byte;
    logic [31:0] generation;
    logic [31:0] arrival_time;

    modport source (
        output valid, kind, in_byte, last_byte, generation, arrival_time,
        input  ready
    );
    modport sink (
        input  valid, kind, in_byte, last_byte, generation, arrival_time,
        output ready
    );
endinterface

// Response channel: one result word per request word
interface rxq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [31:0] out_generation;
    logic [8:0]  out_length;
    logic [31:0] out_arrival;
    logic [31:0] overflow_count;
    logic [2:0]  high_water;
    logic [2:0]  queue_depth;

    modport source (
        output valid, status, out_byte, out_last, out_generation, out_length,
               out_arrival, overflow_count, high_water, queue_depth,
        input  ready
    );
    modport sink (
        input  valid, status, out_byte, out_last, out_generation, out_length,
               out_arrival, overflow_count, high_water, queue_depth,
        output ready
    );
endinterface

// File: sv/rxq_store.sv
// Payload and slot metadata memories, synchronous read with write forwarding
module rxq_store
    import rxq_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 256,
    localparam int SW = $clog2(SLOTS),
    localparam int CW = $clog2(SLOT_BYTES + 1),
    localparam int AW = $clog2(SLOTS * SLOT_BYTES)
)
(
    input  logic          clk,
    input  logic          pay_we,
    input  logic [AW-1:0] pay_waddr,
    input  logic [7:0]    pay_wdata,
    input  logic [AW-1:0] pay_raddr,
    output logic [7:0]    pay_rdata,
    input  logic          meta_we,
    input  logic [SW-1:0] meta_waddr,
    input  slot_tag_t     meta_wtag,
    input  logic [CW-1:0] meta_wlen,
    input  logic [SW-1:0] meta_raddr,
    output slot_tag_t     meta_rtag,
    output logic [CW-1:0] meta_rlen
);

    logic [7:0]    pay_mem [SLOTS*SLOT_BYTES];
    slot_tag_t     tag_mem [SLOTS];
    logic [CW-1:0] len_mem [SLOTS];

    logic [7:0]    pay_rdata_reg;
    slot_tag_t     meta_rtag_reg;
    logic [CW-1:0] meta_rlen_reg;

    // Payload bytes; a write to the address being read is passed through
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_waddr] <= pay_wdata;
        end
        if (pay_we && (pay_waddr == pay_raddr))
        begin
            pay_rdata_reg <= pay_wdata;
        end
        else
        begin
            pay_rdata_reg <= pay_mem[pay_raddr];
        end
    end

    // Slot tag and length, same forwarding rule
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            tag_mem[meta_waddr] <= meta_wtag;
            len_mem[meta_waddr] <= meta_wlen;
        end
        if (meta_we && (meta_waddr == meta_raddr))
        begin
            meta_rtag_reg <= meta_wtag;
            meta_rlen_reg <= meta_wlen;
        end
        else
        begin
            meta_rtag_reg <= tag_mem[meta_raddr];
            meta_rlen_reg <= len_mem[meta_raddr];
        end
    end

    assign pay_rdata = pay_rdata_reg;
    assign meta_rtag = meta_rtag_reg;
    assign meta_rlen = meta_rlen_reg;

endmodule

// File: sv/rx_packet_ring_queue.sv
// Channel  Dir  Word contents
// -------  ---  ---------------------------------------------------------------
// req      in   kind, in_byte, last_byte, generation, arrival_time
// rsp      out  status, out_byte, out_last, out_generation, out_length,
//               out_arrival, overflow_count, high_water, queue_depth
//
// One request word is taken per cycle; its result sits in the output register
// from the next cycle on. The memories are read every cycle at the address
// the next pop will need (tail slot, read offset), so pops run back to back.
// Reset clears pointers, counters and the output valid; memories keep
// garbage until written. req.ready drops only while a result waits in rsp.
module rx_packet_ring_queue
    import rxq_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 256
)
(
    input  logic    clk,
    input  logic    rst_n,
    rxq_req_if.sink   req,
    rxq_rsp_if.source rsp
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOT_BYTES + 1);
    localparam int AW = $clog2(SLOTS * SLOT_BYTES);

    // Control state
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [AW-1:0] head_base_reg, head_base_next;
    logic [AW-1:0] tail_base_reg, tail_base_next;
    logic [CW-1:0] wcnt_reg, wcnt_next;
    logic          too_long_reg, too_long_next;
    logic [CW-1:0] roff_reg, roff_next;
    logic [31:0]   ovf_reg, ovf_next;
    logic [SW-1:0] peak_reg, peak_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    status_t       status_reg, status_next;
    logic [7:0]    obyte_reg, obyte_next;
    logic          olast_reg, olast_next;
    slot_tag_t     otag_reg, otag_next;
    logic [8:0]    olen_reg, olen_next;
    logic [SW-1:0] depth_reg, depth_next;

    // Memory side
    logic          pay_we;
    logic [AW-1:0] pay_waddr;
    logic [7:0]    pay_rdata;
    logic          meta_we;
    slot_tag_t     meta_wtag;
    slot_tag_t     meta_rtag;
    logic [CW-1:0] meta_rlen;

    logic          accept;
    logic [SW-1:0] head_inc;
    logic [CW-1:0] roff_inc;
    logic [SW:0]   depth_diff;

    function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] idx);
        return (idx == SW'(SLOTS - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] base_next(input logic [AW-1:0] base,
                                                input logic [SW-1:0] idx);
        return (idx == SW'(SLOTS - 1)) ? '0 : base + AW'(SLOT_BYTES);
    endfunction

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign meta_wtag = '{generation: req.generation, arrival: req.arrival_time};
    assign head_inc  = ring_next(head_reg);
    assign roff_inc  = roff_reg + 1'b1;

    // Item processing
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        head_base_next = head_base_reg;
        tail_base_next = tail_base_reg;
        wcnt_next      = wcnt_reg;
        too_long_next  = too_long_reg;
        roff_next      = roff_reg;
        ovf_next       = ovf_reg;
        pay_we         = 1'b0;
        pay_waddr      = head_base_reg + AW'(wcnt_reg);
        meta_we        = 1'b0;
        status_next    = status_reg;
        obyte_next     = obyte_reg;
        olast_next     = olast_reg;
        otag_next      = otag_reg;
        olen_next      = olen_reg;
        if (accept)
        begin
            obyte_next  = '0;
            olast_next  = 1'b0;
            otag_next   = '0;
            olen_next   = '0;
            if (req.kind == KIND_PUSH)
            begin
                status_next = ST_BYTE_TAKEN;
                if (wcnt_reg < CW'(SLOT_BYTES))
                begin
                    pay_we    = 1'b1;
                    wcnt_next = wcnt_reg + 1'b1;
                end
                else
                begin
                    too_long_next = 1'b1;
                end
                if (req.last_byte)
                begin
                    if (too_long_next)
                    begin
                        status_next = ST_TOO_LONG;
                    end
                    else if (head_inc == tail_reg)
                    begin
                        ovf_next    = ovf_reg + 1'b1;
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        meta_we        = 1'b1;
                        head_next      = head_inc;
                        head_base_next = base_next(head_base_reg, head_reg);
                        status_next    = ST_QUEUED;
                    end
                    wcnt_next     = '0;
                    too_long_next = 1'b0;
                end
            end
            else if (tail_reg == head_reg)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_BYTE_READ;
                obyte_next  = pay_rdata;
                otag_next   = meta_rtag;
                olen_next   = 9'(meta_rlen);
                if (roff_inc >= meta_rlen)
                begin
                    olast_next     = 1'b1;
                    roff_next      = '0;
                    tail_next      = ring_next(tail_reg);
                    tail_base_next = base_next(tail_base_reg, tail_reg);
                end
                else
                begin
                    roff_next = roff_inc;
                end
            end
        end
    end

    // Depth after the item and peak tracking
    always_comb
    begin
        depth_diff = {1'b0, head_next} - {1'b0, tail_next};
        if (head_next < tail_next)
        begin
            depth_diff = depth_diff + (SW+1)'(SLOTS);
        end
        depth_next = SW'(depth_diff);
        peak_next  = (depth_next > peak_reg) ? depth_next : peak_reg;
    end

    // Output valid: set on accept, cleared when taken
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            head_base_reg <= '0;
            tail_base_reg <= '0;
            wcnt_reg      <= '0;
            too_long_reg  <= 1'b0;
            roff_reg      <= '0;
            ovf_reg       <= '0;
            peak_reg      <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            head_base_reg <= head_base_next;
            tail_base_reg <= tail_base_next;
            wcnt_reg      <= wcnt_next;
            too_long_reg  <= too_long_next;
            roff_reg      <= roff_next;
            ovf_reg       <= ovf_next;
            peak_reg      <= peak_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        obyte_reg  <= obyte_next;
        olast_reg  <= olast_next;
        otag_reg   <= otag_next;
        olen_reg   <= olen_next;
    end

    // Memories, read ahead at the next pop position
    rxq_store #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_store (
        .clk        (clk),
        .pay_we     (pay_we),
        .pay_waddr  (pay_waddr),
        .pay_wdata  (req.in_byte),
        .pay_raddr  (tail_base_next + AW'(roff_next)),
        .pay_rdata  (pay_rdata),
        .meta_we    (meta_we),
        .meta_waddr (head_reg),
        .meta_wtag  (meta_wtag),
        .meta_wlen  (wcnt_next == '0 ? wcnt_reg + 1'b1 : wcnt_next),
        .meta_raddr (tail_next),
        .meta_rtag  (meta_rtag),
        .meta_rlen  (meta_rlen)
    );

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.out_byte       = obyte_reg;
    assign rsp.out_last       = olast_reg;
    assign rsp.out_generation = otag_reg.generation;
    assign rsp.out_length     = olen_reg;
    assign rsp.out_arrival    = otag_reg.arrival;
    assign rsp.overflow_count = ovf_reg;
    assign rsp.high_water     = 3'(peak_reg);
    assign rsp.queue_depth    = 3'(depth_reg);

endmodule
